// ===== hw/rtl/bpfa_pkg.sv =====
package bpfa_pkg;

  localparam int FRAMES     = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 32;

  localparam int FIDX_W    = $clog2(FRAMES);
  localparam int COUNT_W   = FIDX_W + 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int FADDR_W   = 28;

  localparam logic [COUNT_W-1:0] FRAMES_C = COUNT_W'(FRAMES);
  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
  localparam logic [16:0] RSV_RESET = 17'd256;
  localparam logic [7:0] AVAILABLE_TYPE = 8'd1;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_SEAL  = 2'd1;
  localparam logic [1:0] CMD_ALLOC = 2'd2;
  localparam logic [1:0] CMD_FREE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_DOUBLE  = 2'd3;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [7:0]  region_type;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [27:0] frame_address;
    logic [16:0] frame_count;
    logic [16:0] used_count;
    logic [63:0] total_bytes;
    logic [63:0] available_bytes;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } wu_ctrl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 found;
    logic [BIT_W-1:0]     idx;
    logic                 hit;
  } wu_res_t;

endpackage

// ===== hw/rtl/bpfa_map_ram.sv =====
module bpfa_map_ram (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [bpfa_pkg::WIDX_W-1:0]          waddr,
  input  logic [bpfa_pkg::WORD_BITS-1:0]       wdata,
  input  logic [bpfa_pkg::WIDX_W-1:0]          raddr,
  output logic [bpfa_pkg::WORD_BITS-1:0]       rdata
);

  logic [bpfa_pkg::WORD_BITS-1:0] mem [bpfa_pkg::MAP_WORDS];
  logic [bpfa_pkg::WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bpfa_word_unit.sv =====
module bpfa_word_unit (
  input  logic [bpfa_pkg::WORD_BITS-1:0] word,
  input  bpfa_pkg::wu_ctrl_t             ctrl,
  output bpfa_pkg::wu_res_t              res
);

  logic [bpfa_pkg::WORD_BITS-1:0] mask;
  logic [bpfa_pkg::WORD_BITS-1:0] avail;
  logic [bpfa_pkg::WORD_BITS-1:0] pick;
  logic [bpfa_pkg::BIT_W-1:0]     idx;
  logic                           found;

  // bits lo..hi inclusive
  assign mask = (bpfa_pkg::WORD_ONES << ctrl.lo)
              & (bpfa_pkg::WORD_ONES >> (bpfa_pkg::BIT_W'(bpfa_pkg::WORD_BITS - 1) - ctrl.hi));

  // free bits inside the window; bits outside count as used
  assign avail = ~word & mask;

  always_comb begin
    idx = '0;
    for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        idx = bpfa_pkg::BIT_W'(i);
      end
    end
  end

  assign found = |avail;
  assign pick  = bpfa_pkg::WORD_BITS'(found) << idx;

  always_comb begin
    res.found = found;
    res.idx   = idx;
    res.hit   = |(word & mask);
    case (ctrl.op)
      bpfa_pkg::OP_CLEAR: res.word = word & ~mask;
      bpfa_pkg::OP_SET:   res.word = word | mask;
      default:            res.word = word | pick;
    endcase
  end

endmodule

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// First-fit page frame allocator over a one-bit-per-frame used map held in a
// single-port-write memory of 2048 words of 32 bits. Commands: add a memory
// region (cmd 0), seal the low reserved frames (cmd 1), allocate the lowest
// free frame (cmd 2), free a frame by byte address (cmd 3); every command
// returns one result beat with status and all counters. After reset the block
// runs a sweep over all 2048 map words that marks every frame used and takes
// no input beat meanwhile; the configuration port stays writable. The work per
// command is set by the read-modify-write loop on the map memory, with a read
// state and a modify state per map word. Add region first sums the totals,
// aligns the base and checks the span, then walks the words touched by the
// page range (none for a non-available type or when no whole page lands below
// the frame total); seal walks the words of the reserve (none with a zero
// reserve); allocate walks the words up to and including the first one holding
// a free frame, or all words below the frame limit when none is free (none
// with a zero frame limit); free walks one word (none when out of range). A new
// beat is taken in the idle cycle that follows, even while the previous result
// still waits on out_stall; a finished command holds in its last cycle only
// while an older result is still stalled.
module bitmap_page_frame_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpfa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bpfa_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [16:0]         cfg_data
);

  localparam int FW = bpfa_pkg::FIDX_W;
  localparam int CW = bpfa_pkg::COUNT_W;
  localparam int BW = bpfa_pkg::BIT_W;
  localparam int XW = bpfa_pkg::WIDX_W;
  localparam int PW = bpfa_pkg::PAGE_SHIFT;
  localparam int SW = 64 - bpfa_pkg::PAGE_SHIFT + 1;   // aligned start frame
  localparam int EW = SW + 1;                          // start plus page count

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_ALIGN  = 3'd3;
  localparam logic [2:0] S_SPAN   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_MODIFY = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [XW-1:0] w_r, w_nxt;
  logic [XW-1:0] w_last_r, w_last_nxt;
  logic [FW-1:0] first_r, first_nxt;
  logic [FW-1:0] last_r, last_nxt;
  bpfa_pkg::in_item_t item_r, item_nxt;
  logic [SW-1:0] start_r, start_nxt;
  logic [63:0] len_adj_r, len_adj_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [63:0] mem_sum_r, mem_sum_nxt;
  logic [63:0] avail_sum_r, avail_sum_nxt;
  logic [16:0] rsv_r;
  logic [1:0]  status_r, status_nxt;
  logic [bpfa_pkg::FADDR_W-1:0] faddr_r, faddr_nxt;
  logic        out_valid_r, out_valid_nxt;
  bpfa_pkg::out_item_t out_data_r, out_data_nxt;

  logic                           ram_we;
  logic [XW-1:0]                  ram_waddr;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_wdata;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_rdata;
  bpfa_pkg::wu_ctrl_t             wu_ctrl;
  bpfa_pkg::wu_res_t              wu_res;

  logic [PW-1:0] page_low;
  logic [PW:0]   page_off;
  logic [EW-1:0] end_w;
  logic [CW-1:0] end_c;
  logic [CW-1:0] seal_n;
  logic [CW-1:0] room;
  logic [31:0]   rel_frame;
  logic          in_take;

  assign in_take   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign page_low   = item_r.region_base[bpfa_pkg::PAGE_SHIFT-1:0];
  assign page_off   = {1'b1, {PW{1'b0}}} - {1'b0, page_low};
  assign end_w      = EW'(start_r) + EW'(len_adj_r[63:bpfa_pkg::PAGE_SHIFT]);
  assign end_c      = (end_w > EW'(bpfa_pkg::FRAMES)) ? bpfa_pkg::FRAMES_C : end_w[CW-1:0];
  assign seal_n     = (rsv_r > bpfa_pkg::FRAMES_C) ? bpfa_pkg::FRAMES_C : rsv_r;
  assign room       = bpfa_pkg::FRAMES_C - used_r;
  assign rel_frame  = 32'(in_data.free_address[31:bpfa_pkg::PAGE_SHIFT]);

  // window of the current word inside the frame range
  always_comb begin
    wu_ctrl.op = op_r;
    wu_ctrl.lo = (w_r == first_r[FW-1:BW]) ? first_r[BW-1:0] : '0;
    wu_ctrl.hi = (w_r == w_last_r) ? last_r[BW-1:0] : '1;
  end

  bpfa_map_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (w_r),
    .rdata (ram_rdata)
  );

  bpfa_word_unit u_word (
    .word (ram_rdata),
    .ctrl (wu_ctrl),
    .res  (wu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    op_nxt        = op_r;
    w_nxt         = w_r;
    w_last_nxt    = w_last_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    item_nxt      = item_r;
    start_nxt     = start_r;
    len_adj_nxt   = len_adj_r;
    limit_nxt     = limit_r;
    used_nxt      = used_r;
    mem_sum_nxt   = mem_sum_r;
    avail_sum_nxt = avail_sum_r;
    status_nxt    = status_r;
    faddr_nxt     = faddr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = w_r;
    ram_wdata     = wu_res.word;

    // drain the result register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        // sweep the map to all used
        ram_we    = 1'b1;
        ram_wdata = bpfa_pkg::WORD_ONES;
        w_nxt     = w_r + 1'b1;
        if (w_r == XW'(bpfa_pkg::MAP_WORDS - 1)) begin
          w_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          item_nxt   = in_data;
          cmd_nxt    = in_data.cmd;
          status_nxt = bpfa_pkg::ST_OK;
          faddr_nxt  = '0;
          unique case (in_data.cmd)
            bpfa_pkg::CMD_ADD: begin
              state_nxt = S_SUM;
            end
            bpfa_pkg::CMD_SEAL: begin
              // count first, then mark frames 0..n-1
              used_nxt = (seal_n >= room) ? bpfa_pkg::FRAMES_C : used_r + seal_n;
              if (seal_n == '0) begin
                state_nxt = S_DONE;
              end else begin
                op_nxt     = bpfa_pkg::OP_SET;
                first_nxt  = '0;
                last_nxt   = FW'(seal_n - 1'b1);
                w_nxt      = '0;
                w_last_nxt = last_nxt[FW-1:BW];
                state_nxt  = S_READ;
              end
            end
            bpfa_pkg::CMD_ALLOC: begin
              if (limit_r == '0) begin
                status_nxt = bpfa_pkg::ST_OOM;
                state_nxt  = S_DONE;
              end else begin
                op_nxt     = bpfa_pkg::OP_FIND;
                first_nxt  = '0;
                last_nxt   = FW'(limit_r - 1'b1);
                w_nxt      = '0;
                w_last_nxt = last_nxt[FW-1:BW];
                state_nxt  = S_READ;
              end
            end
            default: begin
              if (rel_frame >= 32'(limit_r)) begin
                status_nxt = bpfa_pkg::ST_INVALID;
                state_nxt  = S_DONE;
              end else begin
                op_nxt     = bpfa_pkg::OP_CLEAR;
                first_nxt  = FW'(rel_frame);
                last_nxt   = FW'(rel_frame);
                w_nxt      = first_nxt[FW-1:BW];
                w_last_nxt = first_nxt[FW-1:BW];
                state_nxt  = S_READ;
              end
            end
          endcase
        end
      end
      S_SUM: begin
        mem_sum_nxt = mem_sum_r + item_r.region_length;
        if (item_r.region_type == bpfa_pkg::AVAILABLE_TYPE) begin
          avail_sum_nxt = avail_sum_r + item_r.region_length;
          state_nxt     = S_ALIGN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ALIGN: begin
        // round base up to a page, shorten length by the rounding
        start_nxt = SW'(item_r.region_base[63:bpfa_pkg::PAGE_SHIFT]) + SW'(page_low != '0);
        if (page_low == '0) begin
          len_adj_nxt = item_r.region_length;
        end else if (item_r.region_length > 64'(page_off)) begin
          len_adj_nxt = item_r.region_length - 64'(page_off);
        end else begin
          len_adj_nxt = '0;
        end
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        if (EW'(start_r) >= EW'(end_c)) begin
          state_nxt = S_DONE;
        end else begin
          if (end_c > limit_r) begin
            limit_nxt = end_c;
          end
          op_nxt     = bpfa_pkg::OP_CLEAR;
          first_nxt  = start_r[FW-1:0];
          last_nxt   = FW'(end_c - 1'b1);
          w_nxt      = start_r[FW-1:BW];
          w_last_nxt = last_nxt[FW-1:BW];
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        // map word lands in the read register
        state_nxt = S_MODIFY;
      end
      S_MODIFY: begin
        if (cmd_r == bpfa_pkg::CMD_ALLOC) begin
          if (wu_res.found) begin
            ram_we    = 1'b1;
            used_nxt  = (room <= CW'(1)) ? bpfa_pkg::FRAMES_C : used_r + 1'b1;
            faddr_nxt = bpfa_pkg::FADDR_W'({w_r, wu_res.idx}) << bpfa_pkg::PAGE_SHIFT;
            state_nxt = S_DONE;
          end else if (w_r == w_last_r) begin
            status_nxt = bpfa_pkg::ST_OOM;
            state_nxt  = S_DONE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = S_READ;
          end
        end else if (cmd_r == bpfa_pkg::CMD_FREE) begin
          if (wu_res.hit) begin
            ram_we = 1'b1;
            if (used_r != '0) begin
              used_nxt = used_r - 1'b1;
            end
          end else begin
            status_nxt = bpfa_pkg::ST_DOUBLE;
          end
          state_nxt = S_DONE;
        end else begin
          ram_we = 1'b1;
          if (w_r == w_last_r) begin
            state_nxt = S_DONE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = status_r;
          out_data_nxt.frame_address   = faddr_r;
          out_data_nxt.frame_count     = 17'(limit_r);
          out_data_nxt.used_count      = 17'(used_r);
          out_data_nxt.total_bytes     = mem_sum_r;
          out_data_nxt.available_bytes = avail_sum_r;
          state_nxt                    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      w_r         <= '0;
      limit_r     <= '0;
      used_r      <= '0;
      mem_sum_r   <= '0;
      avail_sum_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      limit_r     <= limit_nxt;
      used_r      <= used_nxt;
      mem_sum_r   <= mem_sum_nxt;
      avail_sum_r <= avail_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsv_r <= bpfa_pkg::RSV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rsv_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    op_r       <= op_nxt;
    w_last_r   <= w_last_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    item_r     <= item_nxt;
    start_r    <= start_nxt;
    len_adj_r  <= len_adj_nxt;
    status_r   <= status_nxt;
    faddr_r    <= faddr_nxt;
    out_data_r <= out_data_nxt;
  end

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= bpfa_pkg::FRAMES_C)
    else $error("used count above frame total");

  a_limit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    limit_r <= bpfa_pkg::FRAMES_C)
    else $error("frame limit above frame total");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> (!out_valid_r && in_stall))
    else $error("traffic during map sweep");

  a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODIFY) |-> (w_r <= w_last_r))
    else $error("map word past end of range");

  a_result_follows_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("finished command produced no result beat");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfa_pkg::*;

  // Cycles with no beat on any channel before the run is declared hung. The
  // slowest single command walks all 2048 map words, and the sweep after reset
  // walks all of them as well.
  localparam int WATCHDOG_LIMIT = 40000;
  localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_SHIFT;
  localparam int PHASES = 6;
  localparam int PHASE_BEATS = 84;
  localparam int SCRIPT_ROWS = 25;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [16:0] cfg_data;

  bitmap_page_frame_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow allocator state: one used bit per frame, the frame limit, the used
  // count and the two byte totals, plus the reserve register.
  bit [WORD_BITS-1:0] used_words [MAP_WORDS];
  int unsigned        limit_frames;
  int unsigned        busy_frames;
  int unsigned        low_reserve;
  bit [63:0]          mem_total;
  bit [63:0]          avail_total;

  out_item_t   due_reports [$];  // replies owed by the block, oldest first
  int unsigned handed_out [$];   // frames granted so far, candidates to free

  int  mismatches = 0;
  bit  calm = 1'b0;              // high during the stretch with no idling
  int  sent = 0;
  int  granted = 0;
  int  out_of_memory = 0;
  int  refused = 0;

  // Directed script: one row per request. Rows with a typed-in reply cover the
  // state right after reset and the extremes; the others go to the predictor.
  typedef struct packed {
    in_item_t  req;
    logic      fixed;
    out_item_t want;
  } script_row_t;

  script_row_t script [SCRIPT_ROWS] = '{
    // nothing added yet: allocate runs dry, any free is out of range
    '{'{CMD_ALLOC, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b1,
      '{ST_OOM, 28'h0, 17'd0, 17'd0, 64'h0, 64'h0}},
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b1,
      '{ST_INVALID, 28'h0, 17'd0, 17'd0, 64'h0, 64'h0}},
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'hFFFF_FFFF}, 1'b1,
      '{ST_INVALID, 28'h0, 17'd0, 17'd0, 64'h0, 64'h0}},
    // seal on an all-used map still counts the reserve
    '{'{CMD_SEAL, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b1,
      '{ST_OK, 28'h0, 17'd0, 17'd256, 64'h0, 64'h0}},
    // reserved region of maximal length: total only
    '{'{CMD_ADD, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 32'h0}, 1'b1,
      '{ST_OK, 28'h0, 17'd0, 17'd256, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0}},
    // 256 pages at zero (total wraps), then an unaligned base giving 257..258
    '{'{CMD_ADD, 64'h0, 64'h10_0000, AVAILABLE_TYPE, 32'h0}, 1'b0, '0},
    '{'{CMD_ADD, 64'h10_0001, 64'h3000, AVAILABLE_TYPE, 32'h0}, 1'b0, '0},
    // seal the low 256 so only the partial last word holds free frames
    '{'{CMD_SEAL, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_ALLOC, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_ALLOC, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_ALLOC, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b0, '0},
    // good free, double free with an unaligned address, limit frame
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'h0010_2000}, 1'b0, '0},
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'h0010_2FFF}, 1'b0, '0},
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'h0010_3000}, 1'b0, '0},
    // regions that free nothing: shorter than the rounding, base rounded past
    // the address space, zero length, and a non-available type
    '{'{CMD_ADD, 64'h20_0800, 64'h100, AVAILABLE_TYPE, 32'h0}, 1'b0, '0},
    '{'{CMD_ADD, 64'hFFFF_FFFF_FFFF_F001, 64'hFFFF_FFFF_FFFF_FFFF, AVAILABLE_TYPE,
        32'h0}, 1'b0, '0},
    '{'{CMD_ADD, 64'h5000, 64'h0, AVAILABLE_TYPE, 32'h0}, 1'b0, '0},
    '{'{CMD_ADD, 64'h30_0000, 64'h4000, 8'hFF, 32'h0}, 1'b0, '0},
    // region running past the top frame: clipped, limit goes to the maximum
    '{'{CMD_ADD, 64'h0FFF_0000, 64'h10_0000, AVAILABLE_TYPE, 32'h0}, 1'b0, '0},
    '{'{CMD_ALLOC, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_ALLOC, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b0, '0},
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'h0FFF_F000}, 1'b0, '0},
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'h1000_0000}, 1'b0, '0},
    '{'{CMD_FREE, 64'h0, 64'h0, 8'h00, 32'h0000_0000}, 1'b0, '0},
    '{'{CMD_ALLOC, 64'h0, 64'h0, 8'h00, 32'h0}, 1'b0, '0}
  };

  // Raise the used count by n, clamping at the frame total.
  function automatic void claim_frames(int unsigned n);
    if (n >= FRAMES - busy_frames) busy_frames = FRAMES;
    else busy_frames = busy_frames + n;
  endfunction

  // Apply one request to the shadow state and build the reply it must give.
  function automatic out_item_t predict_frame_report(in_item_t req);
    out_item_t        rep;
    longint unsigned  first, stop, span, off, g;
    int unsigned      f, n;
    bit               found;
    rep = '0;
    case (req.cmd)
      CMD_ADD: begin
        mem_total = mem_total + req.region_length;
        if (req.region_type == AVAILABLE_TYPE) begin
          avail_total = avail_total + req.region_length;
          // round the base up to a page, trim the length by the same amount,
          // then keep whole pages only; no wrap anywhere
          first = req.region_base >> PAGE_SHIFT;
          span = req.region_length;
          off = req.region_base & (PAGE_BYTES - 1);
          if (off != 0) begin
            first = first + 1;
            span = (span > PAGE_BYTES - off) ? span - (PAGE_BYTES - off) : 0;
          end
          stop = first + (span >> PAGE_SHIFT);
          if (stop > longint'(FRAMES)) stop = FRAMES;
          if (first < stop) begin
            for (g = first; g < stop; g++)
              used_words[g / WORD_BITS][g % WORD_BITS] = 1'b0;
            if (stop > limit_frames) limit_frames = 32'(stop);
          end
        end
      end
      CMD_SEAL: begin
        n = (low_reserve > FRAMES) ? FRAMES : low_reserve;
        for (f = 0; f < n; f++) used_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
        claim_frames(n);
      end
      CMD_ALLOC: begin
        // lowest free frame below the limit, skipping full words
        f = 0;
        found = 1'b0;
        while (!found && f < limit_frames) begin
          if (f % WORD_BITS == 0 && used_words[f / WORD_BITS] == WORD_ONES)
            f = f + WORD_BITS;
          else if (!used_words[f / WORD_BITS][f % WORD_BITS])
            found = 1'b1;
          else
            f = f + 1;
        end
        if (found) begin
          used_words[f / WORD_BITS][f % WORD_BITS] = 1'b1;
          claim_frames(1);
          rep.frame_address = 28'(f << PAGE_SHIFT);
        end else begin
          rep.status = ST_OOM;
        end
      end
      default: begin
        f = req.free_address >> PAGE_SHIFT;
        if (f >= limit_frames) begin
          rep.status = ST_INVALID;
        end else if (!used_words[f / WORD_BITS][f % WORD_BITS]) begin
          rep.status = ST_DOUBLE;
        end else begin
          used_words[f / WORD_BITS][f % WORD_BITS] = 1'b0;
          if (busy_frames > 0) busy_frames = busy_frames - 1;
        end
      end
    endcase
    rep.frame_count = 17'(limit_frames);
    rep.used_count = 17'(busy_frames);
    rep.total_bytes = mem_total;
    rep.available_bytes = avail_total;
    return rep;
  endfunction

  // Random request. Every field is filled with noise first so all bits toggle;
  // most requests are then shaped into sensible regions and frees of frames
  // actually handed out, the rest stay as noise.
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned pick, k, frame, pages;
    req.cmd = 2'($urandom);
    req.region_base = {$urandom, $urandom};
    req.region_length = {$urandom, $urandom};
    req.region_type = 8'($urandom);
    req.free_address = $urandom;
    pick = $urandom_range(99);
    if (pick < 30) begin
      req.cmd = CMD_ALLOC;
    end else if (pick < 60) begin
      req.cmd = CMD_FREE;
      k = $urandom_range(9);
      if (k < 7 && handed_out.size() > 0) begin
        pick = $urandom_range(handed_out.size() - 1);
        req.free_address = (handed_out[pick] << PAGE_SHIFT) | $urandom_range(PAGE_BYTES - 1);
        handed_out.delete(pick);
      end else if (k < 9) begin
        req.free_address = $urandom_range((limit_frames + 2) * PAGE_BYTES - 1);
      end
    end else if (pick < 90) begin
      req.cmd = CMD_ADD;
      if ($urandom_range(3) != 0) begin
        // mostly short regions, half of them low in memory; a rare one runs up to the full frame count
        frame = $urandom_range(1) ? $urandom_range(1023) : $urandom_range(FRAMES - 1);
        pages = ($urandom_range(49) == 0) ? $urandom_range(FRAMES) : $urandom_range(1, 48);
        req.region_type = AVAILABLE_TYPE;
        req.region_base = 64'(frame) << PAGE_SHIFT;
        if ($urandom_range(4) == 0)
          req.region_base = req.region_base + 64'($urandom_range(1, PAGE_BYTES - 1));
        req.region_length = 64'(pages) << PAGE_SHIFT;
        if ($urandom_range(3) == 0)
          req.region_length = req.region_length + 64'($urandom_range(PAGE_BYTES - 1));
      end
    end else begin
      req.cmd = CMD_SEAL;
    end
    return req;
  endfunction

  // Compare one field and log it on a miss.
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Present one request beat, hold it until taken, then book the reply.
  // Entered and left at a falling edge.
  task automatic send_request(input in_item_t req, input bit fixed, input out_item_t want);
    out_item_t pred;
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = predict_frame_report(req);
    if (req.cmd == CMD_ALLOC && pred.status == ST_OK)
      handed_out.push_back(pred.frame_address >> PAGE_SHIFT);
    case (pred.status)
      ST_OK:   if (req.cmd == CMD_ALLOC) granted++;
      ST_OOM:  out_of_memory++;
      default: refused++;
    endcase
    due_reports.push_back(fixed ? want : pred);
    sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed reply is back.
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
  endtask

  // Write the reserve register; called with the block idle or, right after reset, during the map sweep.
  task automatic write_reserve(input bit [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    low_reserve = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: stall at random off the falling edge, except in the calm
  // stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 13);
    end
  end

  // Check every reply beat against the oldest owed reply.
  always @(posedge clk) begin : watch_replies
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_reports.size() == 0) begin
        $error("reply beat with nothing owed: status %0d, frame_address 0x%0h",
               out_data.status, out_data.frame_address);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("frame_address", want.frame_address, out_data.frame_address);
        check_field("frame_count", want.frame_count, out_data.frame_count);
        check_field("used_count", want.used_count, out_data.used_count);
        check_field("total_bytes", want.total_bytes, out_data.total_bytes);
        check_field("available_bytes", want.available_bytes, out_data.available_bytes);
      end
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no beat for %0d cycles, %0d replies still owed",
             WATCHDOG_LIMIT, due_reports.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    bit [16:0] reserves [PHASES];
    int        i, p, j, random_sent;

    // Every input known from time zero, with reset held low.
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;

    // Shadow state after reset: every frame used, counters zero.
    foreach (used_words[w]) used_words[w] = WORD_ONES;
    limit_frames = 0;
    busy_frames = 0;
    mem_total = '0;
    avail_total = '0;
    low_reserve = RSV_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed script with the reserve at its reset value.
    write_reserve(RSV_RESET);
    for (i = 0; i < SCRIPT_ROWS; i++)
      send_request(script[i].req, script[i].fixed, script[i].want);
    drain_replies();

    // Random phases, each under its own reserve setting: none, all frames,
    // above the frame total, then some ordinary values. Each phase ends with
    // the sender held until every reply is in.
    reserves[0] = 17'd0;
    reserves[1] = 17'(FRAMES);
    reserves[2] = 17'h1FFFF;
    reserves[3] = 17'($urandom_range(1, 4096));
    reserves[4] = RSV_RESET;
    reserves[5] = 17'($urandom_range(FRAMES));
    random_sent = 0;
    for (p = 0; p < PHASES; p++) begin
      write_reserve(reserves[p]);
      for (j = 0; j < PHASE_BEATS; j++) begin
        // no idling on either side for a hundred beats in the middle
        calm = (random_sent >= 200 && random_sent < 300);
        send_request(random_request(), 1'b0, '0);
        random_sent++;
      end
      drain_replies();
    end
    calm = 1'b0;

    // Let any stray beat show up before closing.
    repeat (50) @(posedge clk);

    $display("Covered %0d requests (%0d scripted) under %0d reserve settings.",
             sent, SCRIPT_ROWS, PHASES + 1);
    $display("Frames granted %0d, out-of-memory replies %0d, refused frees %0d.",
             granted, out_of_memory, refused);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
